>>> hw/rtl/cmbf_pkg.sv
package cmbf_pkg;

   localparam int SAMPLE_W = 16;
   localparam int DELAY_W  = 11;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   // Register indexes on the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_FEEDBACK_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY_SAMPLES = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN          = 2'd2;

   // Q2.14 unity gain, used as the feedback clamp
   localparam logic signed [SAMPLE_W-1:0] GAIN_POS_ONE = 16'sd16384;
   localparam logic signed [SAMPLE_W-1:0] GAIN_NEG_ONE = -16'sd16384;

   // Half an LSB of the Q1.15 result inside the Q3.29 product
   localparam logic signed [32:0] ROUND_BIAS = 33'sd8192;

   localparam logic signed [19:0] SUM_MAX = 20'sd32767;
   localparam logic signed [19:0] SUM_MIN = -20'sd32768;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

   typedef struct packed {
      logic                       feedback_mode;
      logic [DELAY_W-1:0]         delay_samples;
      logic signed [SAMPLE_W-1:0] gain;
   } cfg_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       clipped;
   } result_type;

endpackage

>>> hw/rtl/multichannel_comb_filter.sv
// Multichannel comb filter, FIR or IIR, one Q1.15 sample per item.
// Input items (req_) carry a sample, a channel number and a block-end mark;
// result items (rsp_) carry y = x + g * d saturated to 16 bits, a clip flag
// and copies of the channel and block-end mark. d is the value the same
// channel stored delay_samples items earlier: the input in FIR mode, the
// saturated output in IIR mode. The csr_ port writes feedback_mode (0),
// delay_samples (1) and gain (2); write it only while the filter is idle.
// Throughput: one item per cycle while rsp_ready is high. An accepted item
// passes the compute stage, then the output register, to rsp_. One delay
// memory read (at accept) and one write (when the item leaves the compute
// stage) per item set that pace; back-to-back same-address hits are forwarded.
// Reset clears registers, pointers and per-channel wrap flags at once; an
// entry not yet written since reset reads as zero by its wrap flag and
// pointer, so no memory clearing pass is needed and req_ready is high in
// the cycle after reset. When the receiver stalls the output register
// holds its item, the compute stage holds one more, then req_ready drops.
module multichannel_comb_filter #(
   parameter int MAX_DELAY = 1024,
   parameter int CHANNELS  = 2
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // input items
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [cmbf_pkg::SAMPLE_W-1:0] req_sample_in,
   input  logic                                 req_channel,
   input  logic                                 req_block_end,
   // result items
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [cmbf_pkg::SAMPLE_W-1:0] rsp_sample_out,
   output logic                                 rsp_out_channel,
   output logic                                 rsp_clipped,
   output logic                                 rsp_out_block_end,
   // configuration writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [cmbf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [cmbf_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int AW    = $clog2(MAX_DELAY);              // ring pointer
   localparam int PW    = $clog2(MAX_DELAY + 1) + 1;      // pointer arithmetic
   localparam int CIW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int DEPTH = CHANNELS * MAX_DELAY;
   localparam int MW    = (DEPTH > 2) ? $clog2(DEPTH) : 1;

   cmbf_pkg::cfg_type    cfg;
   cmbf_pkg::result_type arith_res;

   // Per-channel ring state
   logic [AW-1:0] wp_ff   [CHANNELS];
   logic [AW-1:0] wp_in   [CHANNELS];
   logic          wrap_ff [CHANNELS];
   logic          wrap_in [CHANNELS];

   // Accept stage
   logic           acc;
   logic           known;
   logic [CIW-1:0] chi;
   logic [AW-1:0]  wp_cur;
   logic           wrap_cur;
   logic [PW-1:0]  wp_x;
   logic [PW-1:0]  wp_next;
   logic [PW-1:0]  d_eff;
   logic [PW-1:0]  rd_x;
   logic           entry_hit;
   logic [MW-1:0]  rd_addr;
   logic [MW-1:0]  wr_addr;
   logic           fwd;

   // Compute stage
   logic                                 s1_valid_ff, s1_valid_in;
   logic signed [cmbf_pkg::SAMPLE_W-1:0] s1_x_ff;
   logic                                 s1_ch_ff;
   logic                                 s1_be_ff;
   logic                                 s1_known_ff;
   logic                                 s1_hit_ff;
   logic                                 s1_fwd_ff;
   logic [cmbf_pkg::SAMPLE_W-1:0]        s1_fwd_data_ff;
   logic [MW-1:0]                        s1_waddr_ff;
   logic                                 s1_adv;
   logic [cmbf_pkg::SAMPLE_W-1:0]        ram_q;
   logic signed [cmbf_pkg::SAMPLE_W-1:0] past;
   logic signed [cmbf_pkg::SAMPLE_W-1:0] s1_y;
   logic                                 s1_clip;
   logic [cmbf_pkg::SAMPLE_W-1:0]        s1_wdata;

   // Output register
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic signed [cmbf_pkg::SAMPLE_W-1:0] rsp_sample_ff;
   logic                                 rsp_ch_ff;
   logic                                 rsp_clip_ff;
   logic                                 rsp_be_ff;

   cmbf_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // ---------------------------------------------------------------
   // Handshake: the compute stage moves on whenever the output
   // register is empty or being drained; a new item enters behind it.
   // ---------------------------------------------------------------
   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign acc       = req_valid && req_ready;

   // ---------------------------------------------------------------
   // Accept stage: pick the channel ring, form read and write addresses.
   // ---------------------------------------------------------------
   always_comb begin
      known    = (CHANNELS > 1) || !req_channel;
      chi      = known ? CIW'(req_channel) : '0;
      wp_cur   = wp_ff[chi];
      wrap_cur = wrap_ff[chi];
      wp_x     = PW'(wp_cur);

      // zero delay acts as one, long delay is cut to the ring length
      if (cfg.delay_samples == '0) begin
         d_eff = PW'(1);
      end else if (32'(cfg.delay_samples) > 32'(MAX_DELAY)) begin
         d_eff = PW'(MAX_DELAY);
      end else begin
         d_eff = PW'(cfg.delay_samples);
      end

      if (wp_x >= d_eff) begin
         rd_x = wp_x - d_eff;
      end else begin
         rd_x = wp_x + PW'(MAX_DELAY) - d_eff;
      end

      // entries behind the pointer, or anything once the ring has wrapped,
      // were written since reset; all others are read as zero
      entry_hit = wrap_cur || (wp_x >= d_eff);

      rd_addr = MW'(chi) * MW'(MAX_DELAY) + MW'(rd_x[AW-1:0]);
      wr_addr = MW'(chi) * MW'(MAX_DELAY) + MW'(wp_cur);

      // item leaving the compute stage writes this same edge
      fwd = s1_valid_ff && s1_known_ff && (s1_waddr_ff == rd_addr);

      wp_next = wp_x + PW'(1);
   end

   // Advance the ring pointer of the channel an item belongs to
   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         wp_in[c]   = wp_ff[c];
         wrap_in[c] = wrap_ff[c];
      end
      if (acc && known) begin
         if (wp_next >= PW'(MAX_DELAY)) begin
            wp_in[chi]   = '0;
            wrap_in[chi] = 1'b1;
         end else begin
            wp_in[chi] = wp_next[AW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            wp_ff[c]   <= '0;
            wrap_ff[c] <= 1'b0;
         end
      end else begin
         for (int c = 0; c < CHANNELS; c++) begin
            wp_ff[c]   <= wp_in[c];
            wrap_ff[c] <= wrap_in[c];
         end
      end
   end

   cmbf_delay_ram #(
      .DEPTH (DEPTH),
      .AW    (MW)
   ) u_ram (
      .clock   (clock),
      .rd_en   (acc && known),
      .rd_addr (rd_addr),
      .rd_data (ram_q),
      .wr_en   (s1_adv && s1_known_ff),
      .wr_addr (s1_waddr_ff),
      .wr_data (s1_wdata)
   );

   // ---------------------------------------------------------------
   // Compute stage: merge forwarded data, multiply-add, saturate.
   // ---------------------------------------------------------------
   always_comb begin
      if (!s1_hit_ff) begin
         past = '0;
      end else if (s1_fwd_ff) begin
         past = $signed(s1_fwd_data_ff);
      end else begin
         past = $signed(ram_q);
      end
   end

   cmbf_arith u_arith (
      .feedback_mode (cfg.feedback_mode),
      .gain          (cfg.gain),
      .x             (s1_x_ff),
      .past          (past),
      .result        (arith_res)
   );

   always_comb begin
      if (s1_known_ff) begin
         s1_y    = arith_res.sample;
         s1_clip = arith_res.clipped;
      end else begin
         // unknown channel passes the sample through untouched
         s1_y    = s1_x_ff;
         s1_clip = 1'b0;
      end
      s1_wdata = cfg.feedback_mode ? s1_y : s1_x_ff;
   end

   always_comb begin
      if (acc) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Load payload only on accept; hold it while stalled
   always_ff @(posedge clock) begin
      if (acc) begin
         s1_x_ff        <= req_sample_in;
         s1_ch_ff       <= req_channel;
         s1_be_ff       <= req_block_end;
         s1_known_ff    <= known;
         s1_hit_ff      <= entry_hit;
         s1_fwd_ff      <= fwd;
         s1_fwd_data_ff <= s1_wdata;
         s1_waddr_ff    <= wr_addr;
      end
   end

   // ---------------------------------------------------------------
   // Output register
   // ---------------------------------------------------------------
   always_comb begin
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_sample_ff <= s1_y;
         rsp_ch_ff     <= s1_ch_ff;
         rsp_clip_ff   <= s1_clip;
         rsp_be_ff     <= s1_be_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sample_out    = rsp_sample_ff;
   assign rsp_out_channel   = rsp_ch_ff;
   assign rsp_clipped       = rsp_clip_ff;
   assign rsp_out_block_end = rsp_be_ff;

endmodule

>>> hw/rtl/cmbf_regs.sv
module cmbf_regs (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cmbf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cmbf_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output cmbf_pkg::cfg_type                   cfg
);

   cmbf_pkg::cfg_type cfg_ff;
   cmbf_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            cmbf_pkg::CSR_FEEDBACK_MODE: cfg_in.feedback_mode = csr_wdata[0];
            cmbf_pkg::CSR_DELAY_SAMPLES:
               cfg_in.delay_samples = csr_wdata[cmbf_pkg::DELAY_W-1:0];
            cmbf_pkg::CSR_GAIN:          cfg_in.gain = $signed(csr_wdata);
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.feedback_mode <= 1'b0;
         cfg_ff.delay_samples <= cmbf_pkg::DELAY_W'(1);
         cfg_ff.gain          <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> hw/rtl/cmbf_delay_ram.sv
module cmbf_delay_ram #(
   parameter int DEPTH = 2048,
   parameter int AW    = 11
) (
   input  logic                               clock,
   input  logic                               rd_en,
   input  logic [AW-1:0]                      rd_addr,
   output logic [cmbf_pkg::SAMPLE_W-1:0]      rd_data,
   input  logic                               wr_en,
   input  logic [AW-1:0]                      wr_addr,
   input  logic [cmbf_pkg::SAMPLE_W-1:0]      wr_data
);

   logic [cmbf_pkg::SAMPLE_W-1:0] mem [DEPTH];
   logic [cmbf_pkg::SAMPLE_W-1:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   // Read returns old data on a same-cycle write; the caller forwards
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

>>> hw/rtl/cmbf_arith.sv
module cmbf_arith (
   input  logic                                feedback_mode,
   input  logic signed [cmbf_pkg::SAMPLE_W-1:0] gain,
   input  logic signed [cmbf_pkg::SAMPLE_W-1:0] x,
   input  logic signed [cmbf_pkg::SAMPLE_W-1:0] past,
   output cmbf_pkg::result_type                 result
);

   logic signed [cmbf_pkg::SAMPLE_W-1:0] gain_eff;
   logic signed [31:0]                   prod;
   logic signed [32:0]                   prod_rnd;
   logic signed [18:0]                   scaled;
   logic signed [19:0]                   sum;

   always_comb begin
      gain_eff = gain;
      if (feedback_mode) begin
         if (gain > cmbf_pkg::GAIN_POS_ONE) begin
            gain_eff = cmbf_pkg::GAIN_POS_ONE;
         end else if (gain < cmbf_pkg::GAIN_NEG_ONE) begin
            gain_eff = cmbf_pkg::GAIN_NEG_ONE;
         end
      end
   end

   // Q2.14 x Q1.15, round half up back to Q1.15
   assign prod     = 32'(gain_eff) * 32'(past);
   assign prod_rnd = {prod[31], prod} + cmbf_pkg::ROUND_BIAS;
   assign scaled   = prod_rnd[32:14];
   assign sum      = {{4{x[15]}}, x} + {scaled[18], scaled};

   always_comb begin
      if (sum > cmbf_pkg::SUM_MAX) begin
         result.sample  = cmbf_pkg::SAMPLE_MAX;
         result.clipped = 1'b1;
      end else if (sum < cmbf_pkg::SUM_MIN) begin
         result.sample  = cmbf_pkg::SAMPLE_MIN;
         result.clipped = 1'b1;
      end else begin
         result.sample  = sum[15:0];
         result.clipped = 1'b0;
      end
   end

endmodule
